// ===== hw/rtl/htn_pkg.sv =====
// htn_pkg: shared types and fixed constants of the height-to-normal-map block.
// No dependencies; used by height_to_normal_map.
package htn_pkg;

    // Sequencer states: memory fetch, then per-normal arithmetic.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_WR,
        S_MULA,
        S_MULB,
        S_SQA,
        S_SQB,
        S_SUM,
        S_SQRT,
        S_DIVLD,
        S_DIV,
        S_DFIN,
        S_EMIT
    } htn_state_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_HEIGHT_SCALE = 3'd2;
    localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd3;
    localparam logic [2:0] CFG_ALPHA_MODE   = 3'd4;

    localparam logic       FMT_GRAY   = 1'b0;
    localparam logic       ALPHA_OPAQUE = 1'b0;

    // 1.0 of a height difference after scaling: 255 * 256
    localparam logic [15:0] DIFF_UNIT    = 16'd65280;
    localparam logic [47:0] DIFF_UNIT_SQ = 48'd4261478400;

    localparam int          SQRT_STEPS = 24;   // root bits of a 48-bit radicand
    localparam int          DIV_STEPS  = 15;   // quotient bits, |n| <= 16384
    localparam int          FIX_FRAC   = 14;
    localparam logic [7:0]  PACK_GAIN  = 8'd127;
    localparam logic [8:0]  PACK_BIAS  = 9'd128;

    // floor(s/3) for s <= 765 as (s * 683) >> 11
    localparam logic [9:0]  AVG3_MUL   = 10'd683;
    localparam int          AVG3_SHIFT = 11;

    // One pending normal
    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] hgt;
        logic [7:0] right;
        logic [7:0] lower;
        logic       done;
    } htn_job_t;

endpackage

// ===== hw/rtl/htn_if.sv =====
// htn_if: valid/ready channel interfaces for pixel input and normal output.
// No dependencies.
interface htn_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_or_gray;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red_or_gray, output green, output blue,
                    input ready);
    modport sink   (input valid, input red_or_gray, input green, input blue,
                    output ready);
endinterface

interface htn_nrm_if;
    logic       valid;
    logic       ready;
    logic [9:0] column;
    logic [9:0] row;
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic [7:0] normal_z;
    logic [7:0] alpha;
    logic       last_in_run;
    logic       image_done;

    modport source (output valid, output column, output row, output normal_x,
                    output normal_y, output normal_z, output alpha,
                    output last_in_run, output image_done, input ready);
    modport sink   (input valid, input column, input row, input normal_x,
                    input normal_y, input normal_z, input alpha,
                    input last_in_run, input image_done, output ready);
endinterface

// ===== hw/rtl/height_to_normal_map.sv =====
// height_to_normal_map: raster height image in, bump-map normals out.
// Depends on htn_pkg and the channel interfaces in htn_if.sv.
//
//   channel   dir   payload                                         handshake
//   pix_in    in    red_or_gray, green, blue                         valid/ready
//   nrm_out   out   column, row, normal_x/y/z, alpha,                valid/ready
//                   last_in_run, image_done
//   cfg       in    cfg_we, cfg_index[2:0], cfg_data[15:0]           write only
//
// Sequence: a pixel goes through store fetch and write-back, then each normal
//   it releases (0 to 3) goes through products and sum, the bit-serial square
//   root, the shared restoring divider per component, and the hand-off.
// One pixel is in work at a time; pix_in.ready is high only between pixels.
// The output register decouples the sink: the next pixel is taken while the
//   last normal still waits for its transfer.
// Reset clears counters, sequencer and output valid and loads the configuration defaults; row stores are not cleared.
module height_to_normal_map #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    htn_pix_if.sink        pix_in,
    htn_nrm_if.source      nrm_out,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    localparam int AW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int AH  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = ($clog2(MAX_WIDTH + 1)  > 11) ? $clog2(MAX_WIDTH + 1)  : 11;
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;

    // ---------------- configuration ----------------
    logic [10:0]        width_reg, height_reg;
    logic signed [15:0] scale_reg;
    logic               fmt_reg, amode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd256;
            height_reg <= 11'd256;
            scale_reg  <= 16'sd256;
            fmt_reg    <= 1'b0;
            amode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                htn_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[10:0];
                htn_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[10:0];
                htn_pkg::CFG_HEIGHT_SCALE: scale_reg  <= signed'(cfg_data);
                htn_pkg::CFG_PIXEL_FORMAT: fmt_reg    <= cfg_data[0];
                htn_pkg::CFG_ALPHA_MODE:   amode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp sizes to 1..MAX
    logic [WW-1:0] w_ext, w_eff;
    logic [HW-1:0] h_ext, h_eff;
    always_comb
    begin
        w_ext = WW'(width_reg);
        h_ext = HW'(height_reg);
        if (w_ext == '0)
            w_eff = WW'(1);
        else if (w_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = HW'(1);
        else if (h_ext > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    // ---------------- state ----------------
    htn_pkg::htn_state_t state_reg, state_next;

    logic [AW-1:0] col_reg;
    logic [AH-1:0] row_reg;
    logic [AW-1:0] x_reg;
    logic [AH-1:0] y_reg;
    logic [7:0]    h_reg;
    logic          lastc_reg, lastr_reg;

    logic [7:0]    prev_q, first_q;
    logic [7:0]    pxr_reg, pxr1_reg, fxm1_reg, fx_reg;
    logic [7:0]    rstart_reg, left_reg;

    htn_pkg::htn_job_t job_reg [3];
    logic [2:0]    vld_reg;
    logic [1:0]    cur_reg;

    logic signed [24:0] a_reg, b_reg;
    logic [47:0]   sqa_reg, sqb_reg;
    logic [47:0]   v_reg, r_reg, bit_reg;
    logic [4:0]    step_reg;
    logic [1:0]    k_reg;
    logic [37:0]   rem_reg, dsh_reg;
    logic [14:0]   q_reg;
    logic          neg_reg;
    logic [7:0]    comp_reg [3];

    logic          out_valid_reg;
    logic [9:0]    o_col_reg, o_row_reg;
    logic [7:0]    o_nx_reg, o_ny_reg, o_nz_reg, o_alpha_reg;
    logic          o_last_reg, o_done_reg;

    logic          in_xfer, out_free;
    assign in_xfer  = pix_in.valid && pix_in.ready;
    assign out_free = !out_valid_reg || nrm_out.ready;
    assign pix_in.ready = (state_reg == htn_pkg::S_IDLE);

    // ---------------- position fold and height ----------------
    logic [HW-1:0] rowv;
    logic [AW-1:0] x_now;
    logic [AH-1:0] y_now;
    logic [WW-1:0] x_inc;
    logic [HW-1:0] y_inc;
    logic [9:0]    rgb_sum;
    logic [19:0]   avg_prod;
    logic [7:0]    h_now;

    always_comb
    begin
        rowv  = HW'(row_reg);
        x_now = col_reg;
        if (WW'(col_reg) >= w_eff)
        begin
            x_now = '0;
            rowv  = HW'(row_reg) + HW'(1);
        end
        if (rowv >= h_eff)
            rowv = '0;
        y_now = AH'(rowv);
        x_inc = WW'(x_now) + WW'(1);
        y_inc = HW'(y_now) + HW'(1);
        rgb_sum  = 10'(pix_in.red_or_gray) + 10'(pix_in.green) + 10'(pix_in.blue);
        avg_prod = 20'(rgb_sum) * 20'(htn_pkg::AVG3_MUL);
        h_now = (fmt_reg == htn_pkg::FMT_GRAY) ? pix_in.red_or_gray
                                               : avg_prod[htn_pkg::AVG3_SHIFT +: 8];
    end

    // ---------------- row stores ----------------
    logic [7:0]    prev_mem  [MAX_WIDTH];
    logic [7:0]    first_mem [MAX_WIDTH];
    logic [AW-1:0] prev_ra, first_ra;
    logic          prev_we, first_we;

    always_comb
    begin
        prev_ra  = x_reg;
        first_ra = x_reg - AW'(1);
        case (state_reg)
            htn_pkg::S_RD1:
            begin
                prev_ra  = x_reg + AW'(1);
                first_ra = x_reg;
            end
            htn_pkg::S_RD2: prev_ra = '0;
            default: ;
        endcase
        prev_we  = (state_reg == htn_pkg::S_WR);
        first_we = (state_reg == htn_pkg::S_WR) && (y_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[x_reg] <= h_reg;
        prev_q <= prev_mem[prev_ra];
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
            first_mem[x_reg] <= h_reg;
        first_q <= first_mem[first_ra];
    end

    // ---------------- normals released by this pixel ----------------
    logic [7:0]       rstart_now;
    htn_pkg::htn_job_t job_a, job_b, job_c;
    logic [2:0]       vld_now;
    logic             has_a, has_b, has_c;

    always_comb
    begin
        // row start height is old column 0 of the stored row, taken at column 0
        rstart_now = (x_reg == '0) ? prev_q : rstart_reg;
        has_a = (y_reg != '0);
        has_b = lastr_reg && (x_reg != '0);
        has_c = lastr_reg && lastc_reg;

        job_a.col   = 10'(x_reg);
        job_a.row   = 10'(y_reg - AH'(1));
        job_a.hgt   = pxr_reg;
        job_a.right = lastc_reg ? rstart_now : pxr1_reg;
        job_a.lower = h_reg;
        job_a.done  = 1'b0;

        job_b.col   = 10'(x_reg - AW'(1));
        job_b.row   = 10'(y_reg);
        job_b.hgt   = left_reg;
        job_b.right = h_reg;
        job_b.lower = fxm1_reg;
        job_b.done  = 1'b0;

        // column 0 and row 0 reads see this pixel's own write
        job_c.col   = 10'(x_reg);
        job_c.row   = 10'(y_reg);
        job_c.hgt   = h_reg;
        job_c.right = (x_reg == '0) ? h_reg : prev_q;
        job_c.lower = (y_reg == '0) ? h_reg : fx_reg;
        job_c.done  = 1'b1;

        vld_now = {has_c, has_b, has_a};
    end

    function automatic logic [1:0] lowest(input logic [2:0] v);
        logic [1:0] idx;
        if (v[0])
            idx = 2'd0;
        else if (v[1])
            idx = 2'd1;
        else
            idx = 2'd2;
        return idx;
    endfunction

    logic [2:0] vld_rest;
    assign vld_rest = vld_reg & ~(3'b001 << cur_reg);

    // ---------------- arithmetic ----------------
    htn_pkg::htn_job_t  job_cur;
    logic signed [8:0]  diff;
    logic signed [24:0] sq_in;
    logic signed [49:0] sq_prod;
    logic [47:0]        try_val;
    logic [23:0]        root;
    logic signed [25:0] num;
    logic [24:0]        mag;
    logic signed [15:0] qs;
    logic signed [23:0] pk_prod;
    logic signed [23:0] pk_sum;

    always_comb
    begin
        job_cur = job_reg[cur_reg];
        if (state_reg == htn_pkg::S_MULA)
            diff = signed'({1'b0, job_cur.hgt}) - signed'({1'b0, job_cur.right});
        else
            diff = signed'({1'b0, job_cur.hgt}) - signed'({1'b0, job_cur.lower});
        sq_in   = (state_reg == htn_pkg::S_SQA) ? a_reg : b_reg;
        sq_prod = sq_in * sq_in;
        try_val = r_reg + bit_reg;
        root    = r_reg[23:0];
        case (k_reg)
            2'd0:    num = 26'(b_reg);
            2'd1:    num = -26'(a_reg);
            default: num = signed'(26'(htn_pkg::DIFF_UNIT));
        endcase
        mag = num[25] ? 25'(-num) : 25'(num);
        qs  = neg_reg ? (-signed'(16'(q_reg)) - 16'(rem_reg != '0))
                      : signed'(16'(q_reg));
        pk_prod = 24'(qs) * signed'(24'(htn_pkg::PACK_GAIN));
        pk_sum  = (pk_prod >>> htn_pkg::FIX_FRAC) + signed'(24'(htn_pkg::PACK_BIAS));
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= htn_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htn_pkg::S_IDLE:  if (in_xfer) state_next = htn_pkg::S_RD0;
            htn_pkg::S_RD0:   state_next = htn_pkg::S_RD1;
            htn_pkg::S_RD1:   state_next = htn_pkg::S_RD2;
            htn_pkg::S_RD2:   state_next = htn_pkg::S_WR;
            htn_pkg::S_WR:
                state_next = (vld_now == '0) ? htn_pkg::S_IDLE : htn_pkg::S_MULA;
            htn_pkg::S_MULA:  state_next = htn_pkg::S_MULB;
            htn_pkg::S_MULB:  state_next = htn_pkg::S_SQA;
            htn_pkg::S_SQA:   state_next = htn_pkg::S_SQB;
            htn_pkg::S_SQB:   state_next = htn_pkg::S_SUM;
            htn_pkg::S_SUM:   state_next = htn_pkg::S_SQRT;
            htn_pkg::S_SQRT:
                if (step_reg == 5'(htn_pkg::SQRT_STEPS - 1))
                    state_next = htn_pkg::S_DIVLD;
            htn_pkg::S_DIVLD: state_next = htn_pkg::S_DIV;
            htn_pkg::S_DIV:
                if (step_reg == 5'(htn_pkg::DIV_STEPS - 1))
                    state_next = htn_pkg::S_DFIN;
            htn_pkg::S_DFIN:
                state_next = (k_reg == 2'd2) ? htn_pkg::S_EMIT : htn_pkg::S_DIVLD;
            htn_pkg::S_EMIT:
                if (out_free)
                    state_next = (vld_rest == '0) ? htn_pkg::S_IDLE : htn_pkg::S_MULA;
            default: state_next = htn_pkg::S_IDLE;
        endcase
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (x_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (y_inc >= h_eff) ? '0 : AH'(y_inc);
            end
            else
            begin
                col_reg <= AW'(x_inc);
                row_reg <= y_now;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            htn_pkg::S_IDLE:
                if (in_xfer)
                begin
                    x_reg     <= x_now;
                    y_reg     <= y_now;
                    h_reg     <= h_now;
                    lastc_reg <= (WW'(x_now) == w_eff - WW'(1));
                    lastr_reg <= (HW'(y_now) == h_eff - HW'(1));
                end
            htn_pkg::S_RD1:
            begin
                pxr_reg  <= prev_q;
                fxm1_reg <= first_q;
            end
            htn_pkg::S_RD2:
            begin
                pxr1_reg <= prev_q;
                fx_reg   <= first_q;
            end
            htn_pkg::S_WR:
            begin
                rstart_reg <= rstart_now;
                left_reg   <= h_reg;
                job_reg[0] <= job_a;
                job_reg[1] <= job_b;
                job_reg[2] <= job_c;
                vld_reg    <= vld_now;
                cur_reg    <= lowest(vld_now);
            end
            htn_pkg::S_MULA: a_reg <= 25'(diff) * 25'(scale_reg);
            htn_pkg::S_MULB: b_reg <= 25'(diff) * 25'(scale_reg);
            htn_pkg::S_SQA:  sqa_reg <= sq_prod[47:0];
            htn_pkg::S_SQB:  sqb_reg <= sq_prod[47:0];
            htn_pkg::S_SUM:
            begin
                v_reg    <= sqa_reg + sqb_reg + htn_pkg::DIFF_UNIT_SQ;
                r_reg    <= '0;
                bit_reg  <= 48'(1) << (2 * (htn_pkg::SQRT_STEPS - 1));
                step_reg <= '0;
            end
            htn_pkg::S_SQRT:
            begin
                if (v_reg >= try_val)
                begin
                    v_reg <= v_reg - try_val;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + 5'd1;
                k_reg    <= 2'd0;
            end
            htn_pkg::S_DIVLD:
            begin
                neg_reg  <= num[25];
                rem_reg  <= 38'(mag) << htn_pkg::FIX_FRAC;
                dsh_reg  <= 38'(root) << htn_pkg::FIX_FRAC;
                q_reg    <= '0;
                step_reg <= '0;
            end
            htn_pkg::S_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[13:0], 1'b1};
                end
                else
                    q_reg   <= {q_reg[13:0], 1'b0};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 5'd1;
            end
            htn_pkg::S_DFIN:
            begin
                comp_reg[k_reg] <= pk_sum[7:0];
                k_reg           <= k_reg + 2'd1;
            end
            htn_pkg::S_EMIT:
                if (out_free)
                begin
                    vld_reg <= vld_rest;
                    cur_reg <= lowest(vld_rest);
                end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == htn_pkg::S_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (nrm_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == htn_pkg::S_EMIT && out_free)
        begin
            o_col_reg   <= job_cur.col;
            o_row_reg   <= job_cur.row;
            o_nx_reg    <= comp_reg[0];
            o_ny_reg    <= comp_reg[1];
            o_nz_reg    <= comp_reg[2];
            o_alpha_reg <= (amode_reg == htn_pkg::ALPHA_OPAQUE) ? 8'hFF : job_cur.hgt;
            o_last_reg  <= (vld_rest == '0);
            o_done_reg  <= job_cur.done;
        end
    end

    assign nrm_out.valid       = out_valid_reg;
    assign nrm_out.column      = o_col_reg;
    assign nrm_out.row         = o_row_reg;
    assign nrm_out.normal_x    = o_nx_reg;
    assign nrm_out.normal_y    = o_ny_reg;
    assign nrm_out.normal_z    = o_nz_reg;
    assign nrm_out.alpha       = o_alpha_reg;
    assign nrm_out.last_in_run = o_last_reg;
    assign nrm_out.image_done  = o_done_reg;

    // ---------------- assertions ----------------
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_done_reg) |-> o_last_reg)
        else $error("image_done without last_in_run");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htn_pkg::S_DFIN) |-> (q_reg <= 15'd16384))
        else $error("normal component out of unit range");

    a_emit_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htn_pkg::S_MULA) |-> vld_reg[cur_reg])
        else $error("normal started without a pending job");

    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == htn_pkg::S_RD0))
        else $error("pixel transfer did not start a fetch");

endmodule
